FILE: rtl/plht_pkg.sv
package plht_pkg;

    // Configuration register width and the fixed 12.4 fraction.
    localparam int CFG_W     = 8;
    localparam int FRAC_BITS = 4;
    // Radius in coordinate units: (line_width + brush_width) << FRAC_BITS.
    localparam int RAD_W     = CFG_W + 1 + FRAC_BITS;

    // Configuration register indexes; each register sits at four times its index.
    typedef logic t_reg_idx;
    localparam t_reg_idx REG_LINE_WIDTH  = 1'b0;
    localparam t_reg_idx REG_BRUSH_WIDTH = 1'b1;

    // Multiplier operand sources.
    typedef logic [3:0] t_opnd;
    localparam t_opnd OPND_DX    = 4'd0;
    localparam t_opnd OPND_DY    = 4'd1;
    localparam t_opnd OPND_PX    = 4'd2;
    localparam t_opnd OPND_PY    = 4'd3;
    localparam t_opnd OPND_EX    = 4'd4;
    localparam t_opnd OPND_EY    = 4'd5;
    localparam t_opnd OPND_RAD   = 4'd6;
    localparam t_opnd OPND_R2_LO = 4'd7;
    localparam t_opnd OPND_R2_HI = 4'd8;
    localparam t_opnd OPND_CR_LO = 4'd9;
    localparam t_opnd OPND_CR_HI = 4'd10;
    localparam t_opnd OPND_L2_LO = 4'd11;
    localparam t_opnd OPND_L2_HI = 4'd12;

    // Accumulator operations.
    typedef logic [1:0] t_accop;
    localparam t_accop ACC_NONE = 2'd0;
    localparam t_accop ACC_LOAD = 2'd1;
    localparam t_accop ACC_ADD  = 2'd2;
    localparam t_accop ACC_SUB  = 2'd3;

    // Product alignment in whole operand chunks.
    typedef logic [1:0] t_shift;
    localparam t_shift SH_0 = 2'd0;
    localparam t_shift SH_1 = 2'd1;
    localparam t_shift SH_2 = 2'd2;

    // Register that also takes the new accumulator value.
    typedef logic [2:0] t_dst;
    localparam t_dst DST_NONE  = 3'd0;
    localparam t_dst DST_LEN2  = 3'd1;
    localparam t_dst DST_DOT   = 3'd2;
    localparam t_dst DST_CROSS = 3'd3;
    localparam t_dst DST_R2    = 3'd4;

    typedef struct packed {
        logic   cap;
        t_opnd  sel_a;
        t_opnd  sel_b;
        t_accop op;
        t_shift shift;
        t_dst   dst;
    } t_dp_cmd;

    typedef struct packed {
        logic len2_zero;
        logic dot_neg;
        logic dot_gt_len2;
        logic acc_neg;
        logic pipe_busy;
    } t_dp_stat;

endpackage

FILE: rtl/plht_dpath.sv
module plht_dpath import plht_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [COORD_BITS-1:0] i_vertex_x,
    input  logic [COORD_BITS-1:0] i_vertex_y,
    input  logic [COORD_BITS-1:0] i_query_x,
    input  logic [COORD_BITS-1:0] i_query_y,
    input  logic                  i_first_vertex,
    input  logic [CFG_W-1:0]      i_line_width,
    input  logic [CFG_W-1:0]      i_brush_width,
    output t_dp_stat              o_stat
);

    // Coordinate differences need one extra bit; their magnitudes fit COORD_BITS.
    localparam int DW = COORD_BITS + 1;
    localparam int PW = (COORD_BITS + 1 > RAD_W) ? COORD_BITS + 1 : RAD_W;
    localparam int AW = 4 * PW + 1;

    logic [COORD_BITS-1:0] r_prev_x, r_prev_y, r_qx, r_qy;
    logic [DW-1:0]         r_px, r_py, r_dx, r_dy, r_ex, r_ey;

    logic [2*PW-1:0]       r_prod;
    logic                  r_p_valid, r_p_neg, r_p_load;
    t_shift                r_p_shift;
    t_dst                  r_p_dst;

    logic [AW-1:0]         r_acc;
    logic [2*PW-1:0]       r_len2, r_r2;
    logic signed [2*PW:0]  r_dot;
    logic [2*PW:0]         r_cross;

    logic [CFG_W:0]        w_rsum;
    logic [PW-1:0]         w_rad;
    logic [2*PW:0]         w_cross_abs;
    logic [PW:0]           w_opa, w_opb;
    logic [AW-1:0]         w_shifted, w_term, w_base, w_acc_next;

    function automatic logic [PW-1:0] mag_of(input logic [DW-1:0] v);
        logic [DW-1:0] u;
        u = v[DW-1] ? (~v + 1'b1) : v;
        return PW'(u[COORD_BITS-1:0]);
    endfunction

    // Returns {sign, magnitude} of the selected multiplier operand.
    function automatic logic [PW:0] pick(
        input t_opnd           sel,
        input logic [DW-1:0]   px, py, dx, dy, ex, ey,
        input logic [PW-1:0]   rad,
        input logic [2*PW-1:0] r2, cr, l2
    );
        logic [PW:0] v;
        unique case (sel)
            OPND_DX:    v = {dx[DW-1], mag_of(dx)};
            OPND_DY:    v = {dy[DW-1], mag_of(dy)};
            OPND_PX:    v = {px[DW-1], mag_of(px)};
            OPND_PY:    v = {py[DW-1], mag_of(py)};
            OPND_EX:    v = {ex[DW-1], mag_of(ex)};
            OPND_EY:    v = {ey[DW-1], mag_of(ey)};
            OPND_RAD:   v = {1'b0, rad};
            OPND_R2_LO: v = {1'b0, r2[PW-1:0]};
            OPND_R2_HI: v = {1'b0, r2[2*PW-1:PW]};
            OPND_CR_LO: v = {1'b0, cr[PW-1:0]};
            OPND_CR_HI: v = {1'b0, cr[2*PW-1:PW]};
            OPND_L2_LO: v = {1'b0, l2[PW-1:0]};
            OPND_L2_HI: v = {1'b0, l2[2*PW-1:PW]};
            default:    v = '0;
        endcase
        return v;
    endfunction

    assign w_rsum      = {1'b0, i_line_width} + {1'b0, i_brush_width};
    assign w_rad       = PW'({w_rsum, {FRAC_BITS{1'b0}}});
    assign w_cross_abs = r_cross[2*PW] ? (~r_cross + 1'b1) : r_cross;

    assign w_opa = pick(i_cmd.sel_a, r_px, r_py, r_dx, r_dy, r_ex, r_ey, w_rad,
                        r_r2, w_cross_abs[2*PW-1:0], r_len2);
    assign w_opb = pick(i_cmd.sel_b, r_px, r_py, r_dx, r_dy, r_ex, r_ey, w_rad,
                        r_r2, w_cross_abs[2*PW-1:0], r_len2);

    // Vertex capture: differences against the previous vertex and held point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_qx     <= '0;
            r_qy     <= '0;
        end else if (i_cmd.cap) begin
            r_prev_x <= i_vertex_x;
            r_prev_y <= i_vertex_y;
            if (i_first_vertex) begin
                r_qx <= i_query_x;
                r_qy <= i_query_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_px <= {r_qx[COORD_BITS-1], r_qx} - {r_prev_x[COORD_BITS-1], r_prev_x};
            r_py <= {r_qy[COORD_BITS-1], r_qy} - {r_prev_y[COORD_BITS-1], r_prev_y};
            r_dx <= {i_vertex_x[COORD_BITS-1], i_vertex_x}
                    - {r_prev_x[COORD_BITS-1], r_prev_x};
            r_dy <= {i_vertex_y[COORD_BITS-1], i_vertex_y}
                    - {r_prev_y[COORD_BITS-1], r_prev_y};
            r_ex <= {r_qx[COORD_BITS-1], r_qx} - {i_vertex_x[COORD_BITS-1], i_vertex_x};
            r_ey <= {r_qy[COORD_BITS-1], r_qy} - {i_vertex_y[COORD_BITS-1], i_vertex_y};
        end
    end

    // Multiply stage: unsigned magnitudes, the sign travels with the product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= (i_cmd.op != ACC_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= w_opa[PW-1:0] * w_opb[PW-1:0];
        r_p_neg   <= w_opa[PW] ^ w_opb[PW] ^ (i_cmd.op == ACC_SUB);
        r_p_load  <= (i_cmd.op == ACC_LOAD);
        r_p_shift <= i_cmd.shift;
        r_p_dst   <= i_cmd.dst;
    end

    // Accumulate stage.
    always_comb begin
        unique case (r_p_shift)
            SH_0:    w_shifted = AW'(r_prod);
            SH_1:    w_shifted = AW'(r_prod) << PW;
            SH_2:    w_shifted = AW'(r_prod) << (2 * PW);
            default: w_shifted = AW'(r_prod);
        endcase
    end

    assign w_term     = r_p_neg ? (~w_shifted + 1'b1) : w_shifted;
    assign w_base     = r_p_load ? '0 : r_acc;
    assign w_acc_next = w_base + w_term;

    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_acc <= w_acc_next;
            unique case (r_p_dst)
                DST_LEN2:  r_len2  <= w_acc_next[2*PW-1:0];
                DST_DOT:   r_dot   <= $signed(w_acc_next[2*PW:0]);
                DST_CROSS: r_cross <= w_acc_next[2*PW:0];
                DST_R2:    r_r2    <= w_acc_next[2*PW-1:0];
                default:   ;
            endcase
        end
    end

    assign o_stat.len2_zero   = (r_len2 == '0);
    assign o_stat.dot_neg     = r_dot[2*PW];
    assign o_stat.dot_gt_len2 = (r_dot > $signed({1'b0, r_len2}));
    assign o_stat.acc_neg     = r_acc[AW-1];
    assign o_stat.pipe_busy   = r_p_valid;

endmodule

FILE: rtl/plht_ctrl.sv
module plht_ctrl import plht_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_first_vertex,
    input  logic     i_last_vertex,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output logic     o_hit,
    output t_dp_cmd  o_cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_R2    = 5'd1;
    localparam logic [4:0] ST_L2A   = 5'd2;
    localparam logic [4:0] ST_L2B   = 5'd3;
    localparam logic [4:0] ST_DTA   = 5'd4;
    localparam logic [4:0] ST_DTB   = 5'd5;
    localparam logic [4:0] ST_CRA   = 5'd6;
    localparam logic [4:0] ST_CRB   = 5'd7;
    localparam logic [4:0] ST_NA    = 5'd8;
    localparam logic [4:0] ST_NB    = 5'd9;
    localparam logic [4:0] ST_NC    = 5'd10;
    localparam logic [4:0] ST_F0    = 5'd11;
    localparam logic [4:0] ST_F1    = 5'd12;
    localparam logic [4:0] ST_F2    = 5'd13;
    localparam logic [4:0] ST_F3    = 5'd14;
    localparam logic [4:0] ST_F4    = 5'd15;
    localparam logic [4:0] ST_F5    = 5'd16;
    localparam logic [4:0] ST_F6    = 5'd17;
    localparam logic [4:0] ST_F7    = 5'd18;
    localparam logic [4:0] ST_DRAIN = 5'd19;
    localparam logic [4:0] ST_FIN   = 5'd20;
    localparam logic [4:0] ST_EMIT  = 5'd21;

    logic [4:0] r_state, n_state;
    logic       r_hit_so_far, n_hit_so_far;
    logic       r_last, n_last;
    logic       r_far, n_far;
    logic       r_out_valid, n_out_valid;
    logic       r_out_hit, n_out_hit;
    t_opnd      w_near_x, w_near_y;

    function automatic t_dp_cmd mul_cmd(input t_opnd a, input t_opnd b, input t_accop op,
                                        input t_shift sh, input t_dst dst);
        t_dp_cmd c;
        c.cap   = 1'b0;
        c.sel_a = a;
        c.sel_b = b;
        c.op    = op;
        c.shift = sh;
        c.dst   = dst;
        return c;
    endfunction

    assign w_near_x = r_far ? OPND_EX : OPND_PX;
    assign w_near_y = r_far ? OPND_EY : OPND_PY;

    always_comb begin
        n_state      = r_state;
        n_hit_so_far = r_hit_so_far;
        n_last       = r_last;
        n_far        = r_far;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_hit    = r_out_hit;
        o_cmd        = mul_cmd(OPND_DX, OPND_DX, ACC_NONE, SH_0, DST_NONE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_last    = i_last_vertex;
                    if (i_first_vertex) begin
                        n_hit_so_far = 1'b0;
                        n_state      = i_last_vertex ? ST_EMIT : ST_IDLE;
                    end else begin
                        n_state = ST_R2;
                    end
                end
            end
            ST_R2: begin
                o_cmd   = mul_cmd(OPND_RAD, OPND_RAD, ACC_LOAD, SH_0, DST_R2);
                n_state = ST_L2A;
            end
            ST_L2A: begin
                o_cmd   = mul_cmd(OPND_DX, OPND_DX, ACC_LOAD, SH_0, DST_NONE);
                n_state = ST_L2B;
            end
            ST_L2B: begin
                o_cmd   = mul_cmd(OPND_DY, OPND_DY, ACC_ADD, SH_0, DST_LEN2);
                n_state = ST_DTA;
            end
            ST_DTA: begin
                o_cmd   = mul_cmd(OPND_PX, OPND_DX, ACC_LOAD, SH_0, DST_NONE);
                n_state = ST_DTB;
            end
            ST_DTB: begin
                o_cmd   = mul_cmd(OPND_PY, OPND_DY, ACC_ADD, SH_0, DST_DOT);
                n_state = ST_CRA;
            end
            ST_CRA: begin
                o_cmd   = mul_cmd(OPND_PX, OPND_DY, ACC_LOAD, SH_0, DST_NONE);
                n_state = ST_CRB;
            end
            ST_CRB: begin
                // Length and dot product have settled by now; pick the test.
                o_cmd = mul_cmd(OPND_PY, OPND_DX, ACC_SUB, SH_0, DST_CROSS);
                n_far = !(i_stat.len2_zero || i_stat.dot_neg);
                if (i_stat.len2_zero || i_stat.dot_neg || i_stat.dot_gt_len2) begin
                    n_state = ST_NA;
                end else begin
                    n_state = ST_F0;
                end
            end
            ST_NA: begin
                o_cmd   = mul_cmd(OPND_RAD, OPND_RAD, ACC_LOAD, SH_0, DST_NONE);
                n_state = ST_NB;
            end
            ST_NB: begin
                o_cmd   = mul_cmd(w_near_x, w_near_x, ACC_SUB, SH_0, DST_NONE);
                n_state = ST_NC;
            end
            ST_NC: begin
                o_cmd   = mul_cmd(w_near_y, w_near_y, ACC_SUB, SH_0, DST_NONE);
                n_state = ST_DRAIN;
            end
            ST_F0: begin
                o_cmd   = mul_cmd(OPND_R2_LO, OPND_L2_LO, ACC_LOAD, SH_0, DST_NONE);
                n_state = ST_F1;
            end
            ST_F1: begin
                o_cmd   = mul_cmd(OPND_R2_LO, OPND_L2_HI, ACC_ADD, SH_1, DST_NONE);
                n_state = ST_F2;
            end
            ST_F2: begin
                o_cmd   = mul_cmd(OPND_R2_HI, OPND_L2_LO, ACC_ADD, SH_1, DST_NONE);
                n_state = ST_F3;
            end
            ST_F3: begin
                o_cmd   = mul_cmd(OPND_R2_HI, OPND_L2_HI, ACC_ADD, SH_2, DST_NONE);
                n_state = ST_F4;
            end
            ST_F4: begin
                o_cmd   = mul_cmd(OPND_CR_LO, OPND_CR_LO, ACC_SUB, SH_0, DST_NONE);
                n_state = ST_F5;
            end
            ST_F5: begin
                o_cmd   = mul_cmd(OPND_CR_LO, OPND_CR_HI, ACC_SUB, SH_1, DST_NONE);
                n_state = ST_F6;
            end
            ST_F6: begin
                o_cmd   = mul_cmd(OPND_CR_HI, OPND_CR_LO, ACC_SUB, SH_1, DST_NONE);
                n_state = ST_F7;
            end
            ST_F7: begin
                o_cmd   = mul_cmd(OPND_CR_HI, OPND_CR_HI, ACC_SUB, SH_2, DST_NONE);
                n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                // A non-negative margin means the point is within the radius.
                n_hit_so_far = r_hit_so_far || !i_stat.acc_neg;
                n_state      = r_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit_so_far;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_hit_so_far <= 1'b0;
            r_last       <= 1'b0;
            r_far        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hit_so_far <= n_hit_so_far;
            r_last       <= n_last;
            r_far        <= n_far;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hit <= n_out_hit;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;

endmodule

FILE: rtl/polyline_hit_test_core.sv
// Channel  Direction  Handshake                  Word
// input    in         i_in_valid / o_in_ready    vertex, query point, first/last marks
// output   out        o_out_valid / i_out_ready  hit flag, one per polyline
// config   in         psel/penable/pwrite        line_width at 0x0, brush_width at 0x4
//
// A first vertex that is not last is only captured; a first vertex that is also last goes
// straight to the output word; any other vertex runs one shared multiplier through the
// endpoint distance test or the cross product test. A last vertex then loads the output word.
// The cross product test feeds operand chunks through the single multiplier.
// Reset is synchronous and active low; it restores line_width 1 and brush_width 0.
// A waiting output word does not block input; only a new result waits for it.
module polyline_hit_test_core import plht_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_BITS-1:0] i_vertex_x,
    input  logic [COORD_BITS-1:0] i_vertex_y,
    input  logic [COORD_BITS-1:0] i_query_x,
    input  logic [COORD_BITS-1:0] i_query_y,
    input  logic                  i_first_vertex,
    input  logic                  i_last_vertex,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_hit,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] r_line_width, r_brush_width;
    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width  <= CFG_W'(1);
            r_brush_width <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_LINE_WIDTH:  r_line_width  <= pwdata[CFG_W-1:0];
                REG_BRUSH_WIDTH: r_brush_width <= pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_BRUSH_WIDTH) ? 32'(r_brush_width) : 32'(r_line_width);

    plht_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_first_vertex (i_first_vertex),
        .i_last_vertex  (i_last_vertex),
        .i_out_ready    (i_out_ready),
        .i_stat         (w_stat),
        .o_in_ready     (o_in_ready),
        .o_out_valid    (o_out_valid),
        .o_hit          (o_hit),
        .o_cmd          (w_cmd)
    );

    plht_dpath #(
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .i_first_vertex (i_first_vertex),
        .i_line_width   (r_line_width),
        .i_brush_width  (r_brush_width),
        .o_stat         (w_stat)
    );

`ifndef NO_ASSERTIONS
    // The multiplier pipeline must be empty whenever a new word can enter.
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_stat.pipe_busy)
        else $error("multiplier pipeline busy while accepting input");

    // A one-vertex polyline reports a miss, by way of the emit state, when the output is free.
    a_single_vertex_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_first_vertex && i_last_vertex && !o_out_valid)
        |=> ##1 (o_out_valid && !o_hit))
        else $error("single vertex polyline did not report a miss");

    // A first vertex that does not close the polyline produces no word.
    a_first_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_first_vertex && !i_last_vertex && !o_out_valid)
        |=> !o_out_valid)
        else $error("result emitted for an opening vertex");
`endif

endmodule
